// File: design/hcbp_pkg.sv
// hcbp_pkg: constants, request codes and shared types of the Huffman code bit packer.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package hcbp_pkg;

    // Table geometry and code limits
    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;
    localparam int SYM_W        = 8;
    localparam int SYM_AW       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LEN_W        = 6;
    localparam int CODE_W       = 32;
    localparam int BYTE_W       = 8;

    // Stored length is capped at the code limit and at the code field width
    localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    // Accumulator: up to 7 pending bits plus one full code
    localparam int ACC_W        = (BYTE_W - 1) + CODE_W;

    // Request codes
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_ENCODE = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;

    // One code table entry
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } hcbp_entry_t;

    // Item handed from the request decode to the packer stage
    typedef struct packed {
        logic valid;
        logic flush;
    } hcbp_issue_t;

endpackage

// File: design/hcbp_if.sv
// hcbp_if: valid/ready channel interfaces for the request and packed byte items.
// Depends on hcbp_pkg for field widths.
`timescale 1ns / 1ps

interface hcbp_req_if;
    import hcbp_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          req_type;
    logic [SYM_W-1:0]    symbol;
    logic [LEN_W-1:0]    code_length;
    logic [CODE_W-1:0]   code_bits;

    modport source (output valid, output req_type, output symbol, output code_length,
                    output code_bits, input ready);
    modport sink   (input valid, input req_type, input symbol, input code_length,
                    input code_bits, output ready);
endinterface

interface hcbp_byte_if;
    import hcbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] packed_byte;
    logic              last_of_run;
    logic              padded;

    modport source (output valid, output packed_byte, output last_of_run, output padded,
                    input ready);
    modport sink   (input valid, input packed_byte, input last_of_run, input padded,
                    output ready);
endinterface

// File: design/hcbp_table.sv
// hcbp_table: code table memory, one write and one registered read port,
// with per-entry valid bits so that unwritten entries read as length zero. Uses hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [hcbp_pkg::SYM_AW-1:0] wr_addr,
    input  hcbp_pkg::hcbp_entry_t       wr_data,
    input  logic                        rd_en,
    input  logic [hcbp_pkg::SYM_AW-1:0] rd_addr,
    output hcbp_pkg::hcbp_entry_t       rd_data
);
    import hcbp_pkg::*;

    hcbp_entry_t             mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] valid_reg;
    hcbp_entry_t             rd_data_reg;
    logic                    rd_valid_reg;

    // Memory array and read data register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // An entry never written reads as an absent symbol
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: design/hcbp_packer.sv
// hcbp_packer: table-read stage, bit accumulator and output byte register.
// Uses hcbp_pkg and hcbp_byte_if; takes table read data from hcbp_table.
`timescale 1ns / 1ps

module hcbp_packer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hcbp_pkg::hcbp_issue_t issue,
    input  hcbp_pkg::hcbp_entry_t entry,
    output logic                  ready,
    hcbp_byte_if.source           res
);
    import hcbp_pkg::*;

    // Read stage: item waiting on the table read data
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_flush_reg, s1_flush_next;

    // Accumulator: acc holds left bits, earliest bit at bit 0
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [LEN_W-1:0]  left_reg, left_next;
    logic              emitting_reg, emitting_next;
    logic              flush_reg, flush_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic              out_pad_reg, out_pad_next;

    logic              out_free;
    logic              emit_fire;
    logic              emit_last;
    logic              s1_take;
    logic [ACC_W-1:0]  base_acc;
    logic [LEN_W-1:0]  base_left;

    assign out_free  = !out_valid_reg || res.ready;
    assign emit_fire = emitting_reg && out_free;
    assign emit_last = flush_reg || (left_reg < LEN_W'(2 * BYTE_W));
    assign s1_take   = s1_valid_reg && (!emitting_reg || (emit_fire && emit_last));
    assign ready     = !s1_valid_reg || s1_take;

    // Read stage control
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_flush_next = s1_flush_reg;
        if (ready)
        begin
            s1_valid_next = issue.valid;
            s1_flush_next = issue.flush;
        end
    end

    // Accumulator after this cycle's emission
    always_comb
    begin
        base_acc  = acc_reg;
        base_left = left_reg;
        if (emit_fire)
        begin
            if (flush_reg)
            begin
                base_acc  = '0;
                base_left = '0;
            end
            else
            begin
                base_acc  = acc_reg >> BYTE_W;
                base_left = LEN_W'(left_reg - LEN_W'(BYTE_W));
            end
        end
    end

    // Merge a new item into the accumulator
    always_comb
    begin
        acc_next      = base_acc;
        left_next     = base_left;
        flush_next    = flush_reg;
        emitting_next = emitting_reg && !(emit_fire && emit_last);
        if (s1_take)
        begin
            if (s1_flush_reg)
            begin
                flush_next    = 1'b1;
                emitting_next = (base_left != '0);
            end
            else
            begin
                acc_next      = base_acc | (ACC_W'(entry.code) << base_left[2:0]);
                left_next     = LEN_W'(base_left + entry.len);
                flush_next    = 1'b0;
                emitting_next = (left_next >= LEN_W'(BYTE_W));
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_pad_next   = out_pad_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = acc_reg[BYTE_W-1:0];
            out_last_next  = emit_last;
            out_pad_next   = flush_reg;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_flush_reg  <= 1'b0;
            acc_reg       <= '0;
            left_reg      <= '0;
            emitting_reg  <= 1'b0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_flush_reg  <= s1_flush_next;
            acc_reg       <= acc_next;
            left_reg      <= left_next;
            emitting_reg  <= emitting_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_pad_reg  <= out_pad_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.packed_byte = out_byte_reg;
    assign res.last_of_run = out_last_reg;
    assign res.padded      = out_pad_reg;

    // Idle accumulator holds only a partial byte
    a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
        !emitting_reg |-> left_reg < LEN_W'(BYTE_W))
        else $error("partial byte overflow while idle");

    // Emission only with a full byte, or a non-empty partial byte on flush
    a_emit_amount: assert property (@(posedge clk) disable iff (!rst_n)
        emitting_reg |-> (flush_reg ? (left_reg != '0) : (left_reg >= LEN_W'(BYTE_W))))
        else $error("emission without enough bits");

    // Bits above the live count are always zero, so padding is clean
    a_acc_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg >> left_reg) == '0)
        else $error("stray accumulator bits above count");

    // A padded byte always closes its run
    a_pad_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_pad_reg |-> out_last_reg)
        else $error("padded byte not marked last");

    // A stalled read stage keeps its item
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_take |=> s1_valid_reg && $stable(s1_flush_reg))
        else $error("read stage item lost");

endmodule

// File: design/huffman_code_bit_packer_unit.sv
// huffman_code_bit_packer_unit: top level; request decode, code table and packer.
// Uses hcbp_pkg, hcbp_if, hcbp_table and hcbp_packer.
`timescale 1ns / 1ps

// Each request item loads one code table entry, encodes one symbol, or flushes the
// partial byte. Codes are packed least significant bit first and each full byte is
// delivered as one item on res, with last_of_run on the final byte of a request and
// padded on a flush byte. Table loads and encodes are pipelined through a registered
// table read; an encode that produces n bytes (n is at most 4) occupies the packer
// until its last byte is emitted, since the single output byte register drains the
// accumulator one byte per cycle while the receiver is ready. The table is cleared at
// reset by per-entry valid bits, so the block takes items right after reset; a load
// followed at once by an encode of the same symbol sees the new entry.
module huffman_code_bit_packer_unit (
    input  logic        clk,
    input  logic        rst_n,
    hcbp_req_if.sink    req,
    hcbp_byte_if.source res
);
    import hcbp_pkg::*;

    logic         accept;
    logic         in_range;
    logic         is_load;
    logic         is_encode;
    logic         is_flush;
    logic [LEN_W-1:0]  len_sat;
    logic [CODE_W:0]   mask_wide;
    hcbp_entry_t  wr_data;
    hcbp_entry_t  rd_data;
    hcbp_issue_t  issue;
    logic         packer_ready;
    logic [SYM_AW-1:0] addr;

    // Request decode
    assign accept    = req.valid && req.ready;
    assign in_range  = ({1'b0, req.symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
    assign is_load   = (req.req_type == REQ_LOAD);
    assign is_encode = (req.req_type == REQ_ENCODE);
    assign is_flush  = (req.req_type == REQ_FLUSH);
    assign addr      = req.symbol[SYM_AW-1:0];

    // Load path: saturate the length and drop code bits above it
    assign len_sat   = (req.code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : req.code_length;
    assign mask_wide = ((CODE_W + 1)'(1) << len_sat) - (CODE_W + 1)'(1);
    assign wr_data.len  = len_sat;
    assign wr_data.code = req.code_bits & mask_wide[CODE_W-1:0];

    // Only in-range encodes and flushes reach the packer
    assign issue.valid = accept && ((is_encode && in_range) || is_flush);
    assign issue.flush = is_flush;
    assign req.ready   = packer_ready;

    hcbp_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && is_load && in_range),
        .wr_addr (addr),
        .wr_data (wr_data),
        .rd_en   (accept && is_encode && in_range),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    hcbp_packer u_packer (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (issue),
        .entry (rd_data),
        .ready (packer_ready),
        .res   (res)
    );

endmodule

// File: dv/tb_top.sv
// tb_top: self-checking testbench for huffman_code_bit_packer_unit.
// Depends on hcbp_pkg, hcbp_if and the design; drives requests, predicts packed bytes.
`timescale 1ns / 1ps

module tb_top;
    import hcbp_pkg::*;

    // Unused request code, not named by the package
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int PREDICTED    = -1;
    localparam int RESET_CYCLES = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_PCT     = 20;

    // One packed byte item as seen on the result channel
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              pad;
    } pbyte_t;

    // Directed row: request fields, then typed results or PREDICTED
    typedef struct packed {
        logic [1:0]        rt;
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
        int                n_typed;
        logic [BYTE_W-1:0] tbyte;
        logic              tpad;
    } dir_row_t;

    localparam int DIR_N = 24;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // nothing loaded yet: absent symbol, empty flush, unused code
        '{REQ_ENCODE, 8'd0,   6'd0,  32'h0000_0000, 0, 8'h00, 1'b0},
        '{REQ_FLUSH,  8'd0,   6'd0,  32'h0000_0000, 0, 8'h00, 1'b0},
        '{REQ_UNUSED, 8'd255, 6'd63, 32'hFFFF_FFFF, 0, 8'h00, 1'b0},
        // one full byte from an empty partial byte
        '{REQ_LOAD,   8'd0,   6'd8,  32'h0000_00A5, 0, 8'h00, 1'b0},
        '{REQ_ENCODE, 8'd0,   6'd0,  32'h0000_0000, 1, 8'hA5, 1'b0},
        // longest length field saturates to 32 bits
        '{REQ_LOAD,   8'd255, 6'd63, 32'hFFFF_FFFF, 0, 8'h00, 1'b0},
        '{REQ_ENCODE, 8'd255, 6'd0,  32'h0000_0000, 4, 8'hFF, 1'b0},
        '{REQ_FLUSH,  8'd0,   6'd0,  32'h0000_0000, 0, 8'h00, 1'b0},
        // code bits above the length are dropped; flush pads
        '{REQ_LOAD,   8'd1,   6'd3,  32'hFFFF_FFFD, 0, 8'h00, 1'b0},
        '{REQ_ENCODE, 8'd1,   6'd0,  32'h0000_0000, 0, 8'h00, 1'b0},
        '{REQ_FLUSH,  8'd0,   6'd0,  32'h0000_0000, 1, 8'h05, 1'b1},
        // seven pending bits plus a 32-bit code: four bytes, seven left
        '{REQ_LOAD,   8'd2,   6'd7,  32'h0000_0055, 0, 8'h00, 1'b0},
        '{REQ_ENCODE, 8'd2,   6'd0,  32'h0000_0000, 0, 8'h00, 1'b0},
        '{REQ_UNUSED, 8'd2,   6'd7,  32'h0000_0055, 0, 8'h00, 1'b0},
        '{REQ_ENCODE, 8'd255, 6'd0,  32'h0000_0000, PREDICTED, 8'h00, 1'b0},
        '{REQ_FLUSH,  8'd0,   6'd0,  32'h0000_0000, PREDICTED, 8'h00, 1'b0},
        '{REQ_LOAD,   8'd3,   6'd32, 32'h8000_0001, 0, 8'h00, 1'b0},
        '{REQ_ENCODE, 8'd3,   6'd0,  32'h0000_0000, PREDICTED, 8'h00, 1'b0},
        // zero length makes a symbol absent, then lengths of 33 and 1 bits
        '{REQ_LOAD,   8'd4,   6'd0,  32'hFFFF_FFFF, 0, 8'h00, 1'b0},
        '{REQ_ENCODE, 8'd4,   6'd0,  32'h0000_0000, 0, 8'h00, 1'b0},
        '{REQ_LOAD,   8'd5,   6'd33, 32'h1234_5678, 0, 8'h00, 1'b0},
        '{REQ_ENCODE, 8'd5,   6'd0,  32'h0000_0000, PREDICTED, 8'h00, 1'b0},
        '{REQ_LOAD,   8'd6,   6'd1,  32'h0000_0001, 0, 8'h00, 1'b0},
        '{REQ_ENCODE, 8'd6,   6'd0,  32'h0000_0000, PREDICTED, 8'h00, 1'b0}
    };

    logic clk;
    logic rst_n;

    hcbp_req_if  req_ch ();
    hcbp_byte_if res_ch ();

    huffman_code_bit_packer_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // Predictor state: code table and partial byte
    logic [LEN_W-1:0]  len_tab  [SYMBOL_COUNT];
    logic [CODE_W-1:0] code_tab [SYMBOL_COUNT];
    logic [6:0]        part_bits;
    logic [2:0]        part_cnt;

    pbyte_t            bytes_due [$];
    logic [SYM_W-1:0]  loaded_syms [$];

    int err_count;
    int src_idle_pct;
    int snk_idle_pct;
    logic hold_go;
    logic sink_hold;
    int stall_cnt;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    // Works out the bytes one request releases and advances the predictor state
    function automatic int pack_request(input logic [1:0] rt, input logic [SYM_W-1:0] sym,
                                        input logic [LEN_W-1:0] len,
                                        input logic [CODE_W-1:0] code,
                                        output pbyte_t outv [4]);
        logic [63:0]        mask;
        logic [LEN_W-1:0]   l;
        logic [ACC_W-1:0]   acc;
        int                 total;
        int                 n;
        n = 0;
        for (int i = 0; i < 4; i++)
            outv[i] = '0;
        case (rt)
            REQ_LOAD:
            begin
                if (int'(sym) < SYMBOL_COUNT)
                begin
                    l = (int'(len) > LEN_CAP) ? LEN_W'(LEN_CAP) : len;
                    mask = (64'd1 << l) - 64'd1;
                    len_tab[sym]  = l;
                    code_tab[sym] = code & mask[CODE_W-1:0];
                end
            end
            REQ_ENCODE:
            begin
                if (int'(sym) < SYMBOL_COUNT && len_tab[sym] != '0)
                begin
                    acc = {32'b0, part_bits} | ({7'b0, code_tab[sym]} << part_cnt);
                    total = int'(part_cnt) + int'(len_tab[sym]);
                    while (total >= BYTE_W && n < 4)
                    begin
                        outv[n] = '{acc[7:0], 1'b0, 1'b0};
                        n++;
                        acc = acc >> BYTE_W;
                        total -= BYTE_W;
                    end
                    if (n > 0)
                        outv[n-1].last = 1'b1;
                    part_cnt  = total[2:0];
                    part_bits = acc[6:0];
                end
            end
            REQ_FLUSH:
            begin
                if (part_cnt != '0)
                begin
                    outv[0] = '{{1'b0, part_bits}, 1'b1, 1'b1};
                    n = 1;
                    part_bits = '0;
                    part_cnt  = '0;
                end
            end
            default: ;
        endcase
        return n;
    endfunction

    // Offers one request item; on acceptance queues its expected bytes
    task automatic send_req(input logic [1:0] rt, input logic [SYM_W-1:0] sym,
                            input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code,
                            input int n_typed, input logic [BYTE_W-1:0] tbyte,
                            input logic tpad);
        pbyte_t outv [4];
        int n;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= rt;
        req_ch.symbol      <= sym;
        req_ch.code_length <= len;
        req_ch.code_bits   <= code;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        n = pack_request(rt, sym, len, code, outv);
        // typed rows stand in for the predicted bytes
        if (n_typed != PREDICTED)
        begin
            n = n_typed;
            for (int i = 0; i < n_typed; i++)
                outv[i] = '{tbyte, (i == n_typed - 1), tpad};
        end
        for (int i = 0; i < n; i++)
            bytes_due = {bytes_due, outv[i]};
    endtask

    // Random request: mostly loads and encodes of loaded symbols
    task automatic send_random();
        logic [1:0]        rt;
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
        int r;
        int sel;
        r    = $urandom_range(99);
        sym  = SYM_W'($urandom_range(255));
        len  = LEN_W'($urandom_range(63));
        code = $urandom;
        if (r < 20)
        begin
            rt  = REQ_LOAD;
            sel = $urandom_range(9);
            if (sel < 6)
                len = LEN_W'($urandom_range(12, 1));
            else if (sel < 8)
                len = LEN_W'($urandom_range(32, 13));
            else if (sel == 8)
                len = LEN_W'($urandom_range(63, 33));
            else
                len = '0;
            loaded_syms = {loaded_syms, sym};
        end
        else if (r < 85)
        begin
            rt = REQ_ENCODE;
            if (loaded_syms.size() > 0 && $urandom_range(9) != 0)
                sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
        end
        else if (r < 96)
            rt = REQ_FLUSH;
        else
            rt = REQ_UNUSED;
        send_req(rt, sym, len, code, PREDICTED, 8'h00, 1'b0);
    endtask

    // Result monitor and ready driver
    always @(posedge clk)
    begin
        pbyte_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (bytes_due.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h", res_ch.packed_byte));
            else
            begin
                e = bytes_due[0];
                bytes_due.delete(0);
                if (res_ch.packed_byte !== e.data)
                    report_mismatch($sformatf("packed_byte %02h, expected %02h",
                                              res_ch.packed_byte, e.data));
                if (res_ch.last_of_run !== e.last)
                    report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                              res_ch.last_of_run, e.last));
                if (res_ch.padded !== e.pad)
                    report_mismatch($sformatf("padded %0b, expected %0b",
                                              res_ch.padded, e.pad));
            end
        end
        res_ch.ready <= !sink_hold && ($urandom_range(99) >= snk_idle_pct);
    end

    // Long receiver hold-off, counted here so the block backs up
    initial
    begin
        sink_hold <= 1'b0;
        wait (hold_go);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    // Watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        dir_row_t row;
        src_idle_pct = IDLE_PCT;
        snk_idle_pct = IDLE_PCT;
        hold_go      = 1'b0;
        part_bits    = '0;
        part_cnt     = '0;
        for (int i = 0; i < SYMBOL_COUNT; i++)
        begin
            len_tab[i]  = '0;
            code_tab[i] = '0;
        end
        rst_n = 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_LOAD;
        req_ch.symbol      <= '0;
        req_ch.code_length <= '0;
        req_ch.code_bits   <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_N; i++)
        begin
            row = DIR_ROWS[i];
            send_req(row.rt, row.sym, row.len, row.code, row.n_typed, row.tbyte, row.tpad);
        end

        // random, both sides idling
        for (int i = 0; i < 120; i++)
            send_random();

        // no idling; receiver holds off while the sender keeps offering
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_go      = 1'b1;
        for (int i = 0; i < 80; i++)
            send_random();

        // random, idling again
        src_idle_pct = IDLE_PCT;
        snk_idle_pct = IDLE_PCT;
        for (int i = 0; i < 76; i++)
            send_random();
        req_ch.valid <= 1'b0;

        // drain
        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && bytes_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: huffman_code_bit_packer_unit.f
design/hcbp_pkg.sv
design/hcbp_if.sv
design/hcbp_table.sv
design/hcbp_packer.sv
design/huffman_code_bit_packer_unit.sv
dv/tb_top.sv
